@@ sv/mlt_pkg.sv @@
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants of the MAC learning table.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int MAC_W   = 48;   // Ethernet address
    localparam int PORT_W  = 4;    // stored / reported port
    localparam int LIMIT_W = 8;    // age_limit register
    localparam int CMD_W   = 2;    // command code
    localparam int COUNT_W = 7;    // removed_count field

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd30;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_LEARN  = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // per-entry verdict from the evaluation unit
    typedef struct packed {
        logic match;    // valid and address equal to key
        logic free;     // slot not valid
        logic expire;   // aged past the limit after this tick
    } eval_t;

endpackage

@@ sv/mlt_ram.sv @@
// ----------------------------------------------------------------------------
// mlt_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 61
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/mlt_eval.sv @@
// ----------------------------------------------------------------------------
// mlt_eval
// Shared entry evaluator: address compare, saturating age step, limit check.
// ----------------------------------------------------------------------------
module mlt_eval #(
    parameter int AGE_BITS = 8
) (
    input  logic [AGE_BITS+mlt_pkg::MAC_W+mlt_pkg::PORT_W:0] entry,
    input  logic [mlt_pkg::MAC_W-1:0]                        key,
    input  logic [mlt_pkg::LIMIT_W-1:0]                      age_limit,
    output mlt_pkg::eval_t                                   flags,
    output logic [AGE_BITS-1:0]                              age_next,
    output logic [mlt_pkg::PORT_W-1:0]                       port
);

    localparam int W  = AGE_BITS + mlt_pkg::MAC_W + mlt_pkg::PORT_W + 1;
    localparam int CW = (AGE_BITS > mlt_pkg::LIMIT_W) ? AGE_BITS : mlt_pkg::LIMIT_W;

    logic                      valid;
    logic [mlt_pkg::MAC_W-1:0] mac;
    logic [AGE_BITS-1:0]       age;

    assign valid = entry[W-1];
    assign mac   = entry[W-2 -: mlt_pkg::MAC_W];
    assign port  = entry[AGE_BITS +: mlt_pkg::PORT_W];
    assign age   = entry[AGE_BITS-1:0];

    // age stops at all ones
    assign age_next = (&age) ? age : age + AGE_BITS'(1);

    assign flags.match  = valid && (mac == key);
    assign flags.free   = !valid;
    assign flags.expire = CW'(age_next) > CW'(age_limit);

endmodule

@@ sv/mac_learning_table_with_aging.sv @@
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging
// Bounded fully associative MAC-to-port table with lookup, learn and aging.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake         payload
//  s_       in   s_tvalid/tready   tdata: mac_addr[47:0], in_port[51:48];
//                                  tuser: cmd[1:0]
//  m_       out  m_tvalid/tready   tdata: hit[0], out_port[4:1],
//                                  table_full[5], removed_count[12:6]
//  cfg_     in   cfg_we            cfg_wdata: age_limit
//
//  A lookup, tick or learn scans all ENTRIES slots through the single RAM
//  read port, one slot per cycle; the next command is accepted only once
//  the result of the last one has been placed in the output register.
//  An unused command or a learn on an out-of-range port skips the scan.
//  After reset a clearing pass writes every slot invalid, with s_tready
//  low. The result sits in an output register; a stalled m_tready holds
//  only the final step, and s_tready returns in idle.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging #(
    parameter int ENTRIES  = 64,
    parameter int PORTS    = 16,
    parameter int AGE_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,    // mac_addr[47:0], in_port[51:48], zero pad
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // hit, out_port[4:1], table_full, removed_count[12:6]
    // age limit register
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CNTX_W = CNT_W + mlt_pkg::COUNT_W;
    localparam int W      = AGE_BITS + mlt_pkg::MAC_W + mlt_pkg::PORT_W + 1;
    localparam logic [IDX_W-1:0] LAST    = IDX_W'(ENTRIES - 1);
    localparam logic [31:0]      PORTS_U = 32'(PORTS);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // sequencer / scan pointer
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             issue_reg, issue_next;     // reads still being issued
    logic             pend_reg, pend_next;       // read data valid this cycle
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;

    // latched item
    mlt_pkg::cmd_t               cmd_reg, cmd_next;
    logic [mlt_pkg::MAC_W-1:0]   mac_reg, mac_next;
    logic [mlt_pkg::PORT_W-1:0]  port_reg, port_next;
    logic                        port_ok_reg, port_ok_next;

    // scan results
    logic                        found_reg, found_next;
    logic [IDX_W-1:0]            found_idx_reg, found_idx_next;
    logic [mlt_pkg::PORT_W-1:0]  found_port_reg, found_port_next;
    logic                        free_reg, free_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    // output and config
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [15:0]                 m_tdata_reg, m_tdata_next;
    logic [mlt_pkg::LIMIT_W-1:0] limit_reg, limit_next;

    // RAM port
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [W-1:0]     rd_data, wr_data;

    // evaluator
    mlt_pkg::eval_t              ev;
    logic [AGE_BITS-1:0]         ev_age;
    logic [mlt_pkg::PORT_W-1:0]  ev_port;

    // misc
    mlt_pkg::cmd_t               in_cmd;
    logic                        in_port_ok;
    logic                        out_free;
    logic [CNTX_W-1:0]           cnt_ext;
    logic                        res_hit, res_full;
    logic [mlt_pkg::PORT_W-1:0]  res_port;

    mlt_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mlt_eval #(
        .AGE_BITS (AGE_BITS)
    ) u_eval (
        .entry     (rd_data),
        .key       (mac_reg),
        .age_limit (limit_reg),
        .flags     (ev),
        .age_next  (ev_age),
        .port      (ev_port)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign in_cmd     = mlt_pkg::cmd_t'(s_tuser);
    assign in_port_ok = {28'd0, s_tdata[51:48]} < PORTS_U;
    assign out_free   = !m_tvalid_reg || m_tready;

    // result fields; removed_count keeps only its low 7 bits
    assign cnt_ext  = CNTX_W'(cnt_reg);
    assign res_hit  = found_reg && (cmd_reg != mlt_pkg::CMD_TICK);
    assign res_port = (found_reg && cmd_reg == mlt_pkg::CMD_LOOKUP) ? found_port_reg
                                                                     : '0;
    assign res_full = (cmd_reg == mlt_pkg::CMD_LEARN) && port_ok_reg
                      && !found_reg && !free_reg;

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        cmd_next        = cmd_reg;
        mac_next        = mac_reg;
        port_next       = port_reg;
        port_ok_next    = port_ok_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_port_next = found_port_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        cnt_next        = cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        limit_next      = cfg_we ? cfg_wdata : limit_reg;

        rd_en   = 1'b0;
        rd_addr = addr_reg;
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                // invalidate one slot per cycle
                wr_en     = 1'b1;
                addr_next = addr_reg + IDX_W'(1);
                if (addr_reg == LAST) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = in_cmd;
                    mac_next     = s_tdata[47:0];
                    port_next    = s_tdata[51:48];
                    port_ok_next = in_port_ok;
                    found_next   = 1'b0;
                    free_next    = 1'b0;
                    cnt_next     = '0;
                    addr_next    = '0;
                    if (in_cmd == mlt_pkg::CMD_LOOKUP || in_cmd == mlt_pkg::CMD_TICK
                        || (in_cmd == mlt_pkg::CMD_LEARN && in_port_ok)) begin
                        issue_next = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                // issue: one read per cycle
                if (issue_reg) begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = addr_reg;
                    addr_next     = addr_reg + IDX_W'(1);
                    if (addr_reg == LAST) begin
                        issue_next = 1'b0;
                    end
                end
                // evaluate the slot read last cycle
                if (pend_reg) begin
                    if (ev.match && !found_reg) begin
                        found_next      = 1'b1;
                        found_idx_next  = pend_idx_reg;
                        found_port_next = ev_port;
                    end
                    if (ev.free && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = pend_idx_reg;
                    end
                    if (cmd_reg == mlt_pkg::CMD_TICK && !ev.free) begin
                        wr_en   = 1'b1;
                        wr_addr = pend_idx_reg;
                        if (ev.expire) begin
                            wr_data  = '0;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end else begin
                            wr_data = {rd_data[W-1:AGE_BITS], ev_age};
                        end
                    end
                    if (!issue_reg) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                // learn: refresh the match or fill the first free slot
                if (cmd_reg == mlt_pkg::CMD_LEARN && port_ok_reg
                    && (found_reg || free_reg)) begin
                    wr_en   = 1'b1;
                    wr_addr = found_reg ? found_idx_reg : free_idx_reg;
                    wr_data = {1'b1, mac_reg, port_reg, AGE_BITS'(0)};
                end
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, cnt_ext[mlt_pkg::COUNT_W-1:0], res_full,
                                     res_port, res_hit};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            addr_reg     <= '0;
            issue_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            limit_reg    <= mlt_pkg::LIMIT_RESET;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            issue_reg    <= issue_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            limit_reg    <= limit_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        pend_idx_reg   <= pend_idx_next;
        cmd_reg        <= cmd_next;
        mac_reg        <= mac_next;
        port_reg       <= port_next;
        port_ok_reg    <= port_ok_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_port_reg <= found_port_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        cnt_reg        <= cnt_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule
